@@ design/eqf_pkg.sv @@
// ----------------------------------------------------------------------------
// ECG QRS enhancement filter package
// Result field widths and the flow tag that passes between the pipeline
// sections.
// ----------------------------------------------------------------------------
package eqf_pkg;

  localparam int LowpassW    = 18;
  localparam int HighpassW   = 24;
  localparam int SlopeW      = 26;
  localparam int IntegratedW = 50;

  typedef struct packed {
    logic valid;
    logic start;
  } eqf_tag_t;

endpackage

@@ design/eqf_sample_if.sv @@
// ----------------------------------------------------------------------------
// ECG sample channel
// Valid/ready channel that carries one converter sample per request.
// ----------------------------------------------------------------------------
interface eqf_sample_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] ecg_sample;
  logic                          start_of_record;

  modport source (output valid, ecg_sample, start_of_record, input ready);
  modport sink (input valid, ecg_sample, start_of_record, output ready);
endinterface

@@ design/eqf_result_if.sv @@
// ----------------------------------------------------------------------------
// ECG result channel
// Valid/ready channel carrying low-pass, high-pass, slope and mean per sample.
// ----------------------------------------------------------------------------
interface eqf_result_if ();
  logic                                valid;
  logic                                ready;
  logic signed [eqf_pkg::LowpassW-1:0]  lowpass_value;
  logic signed [eqf_pkg::HighpassW-1:0] highpass_value;
  logic signed [eqf_pkg::SlopeW-1:0]    slope_value;
  logic [eqf_pkg::IntegratedW-1:0]      integrated_value;

  modport source (output valid, lowpass_value, highpass_value, slope_value,
                  integrated_value, input ready);
  modport sink (input valid, lowpass_value, highpass_value, slope_value,
                integrated_value, output ready);
endinterface

@@ design/eqf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module eqf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/eqf_filter.sv @@
// ----------------------------------------------------------------------------
// ECG QRS filter section
// Input register, recursive low-pass, recursive high-pass and five-point
// derivative, one pipeline stage each, with the history of every stage.
// ----------------------------------------------------------------------------
module eqf_filter #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  eqf_sample_if.sink                     sample,
  output eqf_pkg::eqf_tag_t              down_tag,
  input  logic                           down_ready,
  output logic signed [SAMPLE_BITS+5:0]  lowpass,
  output logic signed [SAMPLE_BITS+11:0] highpass,
  output logic signed [SAMPLE_BITS+13:0] slope
);

  localparam int LpW = SAMPLE_BITS + 6;
  localparam int HpW = SAMPLE_BITS + 12;
  localparam int SlW = SAMPLE_BITS + 14;

  logic                          s0_valid;
  logic                          s0_start;
  logic signed [SAMPLE_BITS-1:0] s0_x;
  logic                          s1_valid;
  logic                          s1_start;
  logic signed [LpW-1:0]         s1_lp;
  logic                          s2_valid;
  logic                          s2_start;
  logic signed [LpW-1:0]         s2_lp;
  logic signed [HpW-1:0]         s2_hp;
  logic                          s3_valid;
  logic                          s3_start;
  logic signed [LpW-1:0]         s3_lp;
  logic signed [HpW-1:0]         s3_hp;
  logic signed [SlW-1:0]         s3_slope;

  logic signed [SAMPLE_BITS-1:0] raw_hist [12];
  logic signed [LpW-1:0]         lp_prev [2];
  logic signed [LpW-1:0]         lp_hist [32];
  logic signed [HpW-1:0]         hp_prev;
  logic signed [HpW-1:0]         hp_hist [4];

  logic adv0, adv1, adv2, adv3;
  logic take1, take2, take3;

  logic signed [LpW-1:0] lp_p0, lp_p1, lp_r5, lp_r11, lp_next;
  logic signed [HpW-1:0] hp_p, hp_l15, hp_l16, hp_l31, hp_next;
  logic signed [SlW-1:0] sl_g0, sl_g2, sl_g3, slope_next;

  assign adv3  = !s3_valid || down_ready;
  assign adv2  = !s2_valid || adv3;
  assign adv1  = !s1_valid || adv2;
  assign adv0  = !s0_valid || adv1;
  assign take1 = adv1 && s0_valid;
  assign take2 = adv2 && s1_valid;
  assign take3 = adv3 && s2_valid;

  assign sample.ready = adv0;

  // A start of record sees every history term as zero.
  assign lp_p0   = s0_start ? '0 : lp_prev[0];
  assign lp_p1   = s0_start ? '0 : lp_prev[1];
  assign lp_r5   = s0_start ? '0 : LpW'(raw_hist[5]);
  assign lp_r11  = s0_start ? '0 : LpW'(raw_hist[11]);
  assign lp_next = (lp_p0 <<< 1) - lp_p1 + LpW'(s0_x) - (lp_r5 <<< 1) + lp_r11;

  assign hp_p    = s1_start ? '0 : hp_prev;
  assign hp_l15  = s1_start ? '0 : HpW'(lp_hist[15]);
  assign hp_l16  = s1_start ? '0 : HpW'(lp_hist[16]);
  assign hp_l31  = s1_start ? '0 : HpW'(lp_hist[31]);
  assign hp_next = hp_p - HpW'(s1_lp) + (hp_l15 <<< 5) - (hp_l16 <<< 5) + hp_l31;

  assign sl_g0      = s2_start ? '0 : SlW'(hp_hist[0]);
  assign sl_g2      = s2_start ? '0 : SlW'(hp_hist[2]);
  assign sl_g3      = s2_start ? '0 : SlW'(hp_hist[3]);
  assign slope_next = (SlW'(s2_hp) <<< 1) + sl_g0 - sl_g2 - (sl_g3 <<< 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      for (int k = 0; k < 12; k++) begin
        raw_hist[k] <= '0;
      end
      lp_prev[0] <= '0;
      lp_prev[1] <= '0;
      for (int k = 0; k < 32; k++) begin
        lp_hist[k] <= '0;
      end
      hp_prev <= '0;
      for (int k = 0; k < 4; k++) begin
        hp_hist[k] <= '0;
      end
    end else begin
      if (adv0) begin
        s0_valid <= sample.valid;
      end
      if (adv1) begin
        s1_valid <= s0_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
      if (take1) begin
        raw_hist[0] <= s0_x;
        for (int k = 1; k < 12; k++) begin
          raw_hist[k] <= s0_start ? '0 : raw_hist[k-1];
        end
        lp_prev[0] <= lp_next;
        lp_prev[1] <= lp_p0;
      end
      if (take2) begin
        lp_hist[0] <= s1_lp;
        for (int k = 1; k < 32; k++) begin
          lp_hist[k] <= s1_start ? '0 : lp_hist[k-1];
        end
        hp_prev <= hp_next;
      end
      if (take3) begin
        hp_hist[0] <= s2_hp;
        for (int k = 1; k < 4; k++) begin
          hp_hist[k] <= s2_start ? '0 : hp_hist[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && sample.valid) begin
      s0_x     <= sample.ecg_sample;
      s0_start <= sample.start_of_record;
    end
    if (take1) begin
      s1_lp    <= lp_next;
      s1_start <= s0_start;
    end
    if (take2) begin
      s2_lp    <= s1_lp;
      s2_hp    <= hp_next;
      s2_start <= s1_start;
    end
    if (take3) begin
      s3_lp    <= s2_lp;
      s3_hp    <= s2_hp;
      s3_slope <= slope_next;
      s3_start <= s2_start;
    end
  end

  assign down_tag.valid = s3_valid;
  assign down_tag.start = s3_start;
  assign lowpass        = s3_lp;
  assign highpass       = s3_hp;
  assign slope          = s3_slope;

  // With history cleared the low-pass output is the sample itself.
  a_start_lowpass : assert property (@(posedge clk) disable iff (rst)
    take1 && s0_start |=> s1_lp == LpW'($past(s0_x)))
    else $error("low-pass output after start of record differs from the sample");

endmodule

@@ design/eqf_window.sv @@
// ----------------------------------------------------------------------------
// ECG QRS window section
// Squares the slope and keeps the running total of the last window of squares,
// with the squares held in a circular RAM and one valid bit per entry.
// ----------------------------------------------------------------------------
module eqf_window #(
  parameter int WINDOW_LENGTH = 30,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  eqf_pkg::eqf_tag_t              up_tag,
  output logic                           up_ready,
  input  logic signed [SAMPLE_BITS+5:0]  up_lowpass,
  input  logic signed [SAMPLE_BITS+11:0] up_highpass,
  input  logic signed [SAMPLE_BITS+13:0] up_slope,
  output eqf_pkg::eqf_tag_t              down_tag,
  input  logic                           down_ready,
  output logic signed [SAMPLE_BITS+5:0]  down_lowpass,
  output logic signed [SAMPLE_BITS+11:0] down_highpass,
  output logic signed [SAMPLE_BITS+13:0] down_slope,
  output logic [2*(SAMPLE_BITS+13)+$clog2(WINDOW_LENGTH)-1:0] down_total
);

  localparam int LpW   = SAMPLE_BITS + 6;
  localparam int HpW   = SAMPLE_BITS + 12;
  localparam int SlW   = SAMPLE_BITS + 14;
  localparam int MagW  = SlW - 1;
  localparam int SqW   = 2 * MagW;
  localparam int TotW  = SqW + $clog2(WINDOW_LENGTH);
  localparam int AddrW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  logic                     s4_valid;
  logic                     s4_start;
  logic signed [LpW-1:0]    s4_lp;
  logic signed [HpW-1:0]    s4_hp;
  logic signed [SlW-1:0]    s4_slope;
  logic [SqW-1:0]           s4_sq;
  logic [AddrW-1:0]         s4_pos;
  logic                     s4_fwd;
  logic [SqW-1:0]           s4_fwd_sq;
  logic                     s5_valid;
  logic signed [LpW-1:0]    s5_lp;
  logic signed [HpW-1:0]    s5_hp;
  logic signed [SlW-1:0]    s5_slope;
  logic [TotW-1:0]          s5_total;

  logic [TotW-1:0]          window_total;
  logic [WINDOW_LENGTH-1:0] sq_valid;
  logic [AddrW-1:0]         wpos;

  logic                     adv4, adv5, take4, take5;
  logic signed [SlW-1:0]    abs_slope;
  logic [MagW-1:0]          mag_next;
  logic [SqW-1:0]           sq_next;
  logic [AddrW-1:0]         rd_addr;
  logic [SqW-1:0]           rd_data;
  logic [SqW-1:0]           old_sq;
  logic [TotW-1:0]          total_next;

  assign adv5     = !s5_valid || down_ready;
  assign adv4     = !s4_valid || adv5;
  assign take4    = adv4 && up_tag.valid;
  assign take5    = adv5 && s4_valid;
  assign up_ready = adv4;

  assign abs_slope = up_slope[SlW-1] ? -up_slope : up_slope;
  assign mag_next  = abs_slope[MagW-1:0];
  assign sq_next   = mag_next * mag_next;

  // A start of record rewinds the window to its first entry.
  assign rd_addr = up_tag.start ? '0 : wpos;

  eqf_ram #(
    .WIDTH (SqW),
    .DEPTH (WINDOW_LENGTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (take5),
    .wr_addr (s4_pos),
    .wr_data (s4_sq),
    .rd_en   (take4),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The square leaving the window comes from the RAM, or from the request
  // ahead when that one wrote the same entry on the cycle of the read.
  assign old_sq = s4_start ? '0 :
                  s4_fwd ? s4_fwd_sq :
                  sq_valid[s4_pos] ? rd_data : '0;
  assign total_next = (s4_start ? '0 : window_total) - TotW'(old_sq) + TotW'(s4_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      window_total <= '0;
      sq_valid     <= '0;
      wpos         <= '0;
    end else begin
      if (adv4) begin
        s4_valid <= up_tag.valid;
      end
      if (adv5) begin
        s5_valid <= s4_valid;
      end
      if (take4) begin
        wpos <= (rd_addr == AddrW'(WINDOW_LENGTH - 1)) ? '0 : rd_addr + 1'b1;
      end
      if (take5) begin
        window_total <= total_next;
        for (int k = 0; k < WINDOW_LENGTH; k++) begin
          sq_valid[k] <= (s4_pos == AddrW'(k)) || (!s4_start && sq_valid[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take4) begin
      s4_start  <= up_tag.start;
      s4_lp     <= up_lowpass;
      s4_hp     <= up_highpass;
      s4_slope  <= up_slope;
      s4_sq     <= sq_next;
      s4_pos    <= rd_addr;
      s4_fwd    <= take5 && (s4_pos == rd_addr);
      s4_fwd_sq <= s4_sq;
    end
    if (take5) begin
      s5_lp    <= s4_lp;
      s5_hp    <= s4_hp;
      s5_slope <= s4_slope;
      s5_total <= total_next;
    end
  end

  assign down_tag.valid = s5_valid;
  assign down_tag.start = 1'b0;
  assign down_lowpass   = s5_lp;
  assign down_highpass  = s5_hp;
  assign down_slope     = s5_slope;
  assign down_total     = s5_total;

  a_start_total : assert property (@(posedge clk) disable iff (rst)
    take5 && s4_start |=> window_total == TotW'($past(s4_sq)))
    else $error("window total after start of record is not the first square");

  a_start_valid : assert property (@(posedge clk) disable iff (rst)
    take5 && s4_start |=> $onehot(sq_valid))
    else $error("window entries survived a start of record");

  a_wpos_range : assert property (@(posedge clk) disable iff (rst)
    wpos <= AddrW'(WINDOW_LENGTH - 1))
    else $error("window write position ran past the window");

endmodule

@@ design/eqf_divider.sv @@
// ----------------------------------------------------------------------------
// ECG QRS window divider
// Division of the window total by the window length as a multiplication by
// the rounded-up reciprocal, split into half-width partial products in the
// first stage and summed in the second, which is the result register.
// ----------------------------------------------------------------------------
module eqf_divider #(
  parameter int WINDOW_LENGTH = 30,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  eqf_pkg::eqf_tag_t              up_tag,
  output logic                           up_ready,
  input  logic signed [SAMPLE_BITS+5:0]  up_lowpass,
  input  logic signed [SAMPLE_BITS+11:0] up_highpass,
  input  logic signed [SAMPLE_BITS+13:0] up_slope,
  input  logic [2*(SAMPLE_BITS+13)+$clog2(WINDOW_LENGTH)-1:0] up_total,
  eqf_result_if.source                   result
);

  localparam int LpW         = SAMPLE_BITS + 6;
  localparam int HpW         = SAMPLE_BITS + 12;
  localparam int SlW         = SAMPLE_BITS + 14;
  localparam int LenW        = $clog2(WINDOW_LENGTH);
  localparam int TotW        = 2 * (SAMPLE_BITS + 13) + LenW;
  localparam int Shift       = TotW + LenW;
  localparam int RecW        = TotW + 1;
  localparam int HalfW       = (RecW + 1) / 2;
  localparam int SplitW      = 2 * HalfW;
  localparam int ProdW       = 4 * HalfW;
  localparam int QuoW        = TotW - LenW + 1;
  localparam int LowpassW    = eqf_pkg::LowpassW;
  localparam int HighpassW   = eqf_pkg::HighpassW;
  localparam int SlopeW      = eqf_pkg::SlopeW;
  localparam int IntegratedW = eqf_pkg::IntegratedW;

  function automatic logic [SplitW-1:0] recip_calc();
    logic [ProdW-1:0] num;
    num = ProdW'(1) << Shift;
    return SplitW'((num + ProdW'(WINDOW_LENGTH - 1)) / ProdW'(WINDOW_LENGTH));
  endfunction

  localparam logic [SplitW-1:0] Recip   = recip_calc();
  localparam logic [HalfW-1:0]  RecipLo = Recip[HalfW-1:0];
  localparam logic [HalfW-1:0]  RecipHi = Recip[SplitW-1:HalfW];

  logic                  a_valid;
  logic [SplitW-1:0]     a_ll;
  logic [SplitW-1:0]     a_lh;
  logic [SplitW-1:0]     a_hl;
  logic [SplitW-1:0]     a_hh;
  logic signed [LpW-1:0] a_lp;
  logic signed [HpW-1:0] a_hp;
  logic signed [SlW-1:0] a_slope;
  logic                  b_valid;
  logic [QuoW-1:0]       b_quo;
  logic signed [LpW-1:0] b_lp;
  logic signed [HpW-1:0] b_hp;
  logic signed [SlW-1:0] b_slope;

  logic                  adv_a;
  logic                  adv_b;
  logic [SplitW-1:0]     tot_wide;
  logic [HalfW-1:0]      tot_lo;
  logic [HalfW-1:0]      tot_hi;
  logic [ProdW-1:0]      prod;

  assign adv_b    = !b_valid || result.ready;
  assign adv_a    = !a_valid || adv_b;
  assign up_ready = adv_a;

  assign tot_wide = SplitW'(up_total);
  assign tot_lo   = tot_wide[HalfW-1:0];
  assign tot_hi   = tot_wide[SplitW-1:HalfW];

  assign prod = ProdW'(a_ll) + (ProdW'(a_lh) << HalfW) + (ProdW'(a_hl) << HalfW)
              + (ProdW'(a_hh) << SplitW);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid <= up_tag.valid;
      end
      if (adv_b) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && up_tag.valid) begin
      a_ll    <= tot_lo * RecipLo;
      a_lh    <= tot_lo * RecipHi;
      a_hl    <= tot_hi * RecipLo;
      a_hh    <= tot_hi * RecipHi;
      a_lp    <= up_lowpass;
      a_hp    <= up_highpass;
      a_slope <= up_slope;
    end
    if (adv_b && a_valid) begin
      b_quo   <= prod[Shift +: QuoW];
      b_lp    <= a_lp;
      b_hp    <= a_hp;
      b_slope <= a_slope;
    end
  end

  assign result.valid            = b_valid;
  assign result.lowpass_value    = LowpassW'(b_lp);
  assign result.highpass_value   = HighpassW'(b_hp);
  assign result.slope_value      = SlopeW'(b_slope);
  assign result.integrated_value = IntegratedW'(b_quo);

  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(b_quo))
    else $error("waiting result changed before it was taken");

endmodule

@@ design/ecg_qrs_enhancement_filter.sv @@
// ----------------------------------------------------------------------------
// ECG QRS enhancement filter
// Low-pass, high-pass, derivative, squaring and moving-window average of an
// ECG sample stream, returning all but the squares for each sample.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the result channel takes results.
// From acceptance until the result is offered, a request passes the input register,
// three filter stages, two window stages and a two-stage reciprocal multiply.
// Reset clears all filter history, the window total and the window entries
// at once, so requests are taken from the first cycle after reset.
module ecg_qrs_enhancement_filter #(
  parameter int WINDOW_LENGTH = 30,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic         clk,
  input  logic         rst,
  eqf_sample_if.sink   sample,
  eqf_result_if.source result
);

  localparam int LpW  = SAMPLE_BITS + 6;
  localparam int HpW  = SAMPLE_BITS + 12;
  localparam int SlW  = SAMPLE_BITS + 14;
  localparam int TotW = 2 * (SAMPLE_BITS + 13) + $clog2(WINDOW_LENGTH);

  eqf_pkg::eqf_tag_t     filt_tag;
  logic                  filt_ready;
  logic signed [LpW-1:0] filt_lowpass;
  logic signed [HpW-1:0] filt_highpass;
  logic signed [SlW-1:0] filt_slope;

  eqf_pkg::eqf_tag_t     win_tag;
  logic                  win_ready;
  logic signed [LpW-1:0] win_lowpass;
  logic signed [HpW-1:0] win_highpass;
  logic signed [SlW-1:0] win_slope;
  logic [TotW-1:0]       win_total;

  eqf_filter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .down_tag   (filt_tag),
    .down_ready (filt_ready),
    .lowpass    (filt_lowpass),
    .highpass   (filt_highpass),
    .slope      (filt_slope)
  );

  eqf_window #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .up_tag        (filt_tag),
    .up_ready      (filt_ready),
    .up_lowpass    (filt_lowpass),
    .up_highpass   (filt_highpass),
    .up_slope      (filt_slope),
    .down_tag      (win_tag),
    .down_ready    (win_ready),
    .down_lowpass  (win_lowpass),
    .down_highpass (win_highpass),
    .down_slope    (win_slope),
    .down_total    (win_total)
  );

  eqf_divider #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .up_tag      (win_tag),
    .up_ready    (win_ready),
    .up_lowpass  (win_lowpass),
    .up_highpass (win_highpass),
    .up_slope    (win_slope),
    .up_total    (win_total),
    .result      (result)
  );

endmodule

@@ bench/ecg_qrs_enhancement_filter_tb.sv @@
// ----------------------------------------------------------------------------
// ECG QRS enhancement filter testbench
// Feeds directed and random sample streams through the filter chain with
// random gaps and stalls on both channels. A bit-exact model of the low-pass,
// high-pass, derivative, squaring and window average stages predicts every
// result, which is then compared field by field in arrival order.
// ----------------------------------------------------------------------------
module ecg_qrs_enhancement_filter_tb;

  localparam int WindowLength = 30;
  localparam int SampleBits   = 12;
  localparam int RandomItems  = 650;
  localparam int DrainCycles  = 40;
  localparam int CycleLimit   = 400000;
  localparam int LowpassW     = eqf_pkg::LowpassW;
  localparam int HighpassW    = eqf_pkg::HighpassW;
  localparam int SlopeW       = eqf_pkg::SlopeW;
  localparam int IntegratedW  = eqf_pkg::IntegratedW;

  typedef struct packed {
    logic signed [SampleBits-1:0] ecg_sample;
    logic                         start_of_record;
  } sample_item_t;

  typedef struct packed {
    logic signed [LowpassW-1:0]  lowpass;
    logic signed [HighpassW-1:0] highpass;
    logic signed [SlopeW-1:0]    slope;
    logic [IntegratedW-1:0]      integrated;
  } chain_result_t;

  logic clk;
  logic rst;

  eqf_sample_if #(.SAMPLE_BITS(SampleBits)) sample_ch ();
  eqf_result_if result_ch ();

  ecg_qrs_enhancement_filter #(
    .WINDOW_LENGTH(WindowLength),
    .SAMPLE_BITS(SampleBits)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch)
  );

  logic signed [SampleBits-1:0] recent_samples[12];
  logic signed [LowpassW-1:0]   recent_lowpass[32];
  logic signed [HighpassW-1:0]  recent_highpass[4];
  logic [IntegratedW-1:0]       recent_squares[WindowLength];
  int                           square_slot;
  logic [54:0]                  square_sum;

  sample_item_t  pending_samples[$];
  chain_result_t expected_results[$];

  int     error_count;
  int     samples_sent;
  int     record_starts;
  int     results_checked;
  longint peak_mean;
  int     cycle_count;
  logic   sample_taken;
  int     send_gap;
  bit     send_steady;
  int     stall_left;
  bit     recv_steady;
  sample_item_t next_item;

  function automatic void clear_history();
    foreach (recent_samples[k]) recent_samples[k] = '0;
    foreach (recent_lowpass[k]) recent_lowpass[k] = '0;
    foreach (recent_highpass[k]) recent_highpass[k] = '0;
    foreach (recent_squares[k]) recent_squares[k] = '0;
    square_slot = 0;
    square_sum  = '0;
  endfunction

  function automatic chain_result_t filter_chain_step(sample_item_t item);
    longint        x;
    longint        lp;
    longint        hp;
    longint        slope;
    longint        sq;
    chain_result_t res;
    if (item.start_of_record) begin
      clear_history();
    end
    x  = item.ecg_sample;
    lp = 2 * recent_lowpass[0] - recent_lowpass[1] + x
         - 2 * recent_samples[5] + recent_samples[11];
    hp = recent_highpass[0] - lp + 32 * recent_lowpass[15]
         - 32 * recent_lowpass[16] + recent_lowpass[31];
    slope = 2 * hp + recent_highpass[0] - recent_highpass[2]
            - 2 * recent_highpass[3];
    sq = slope * slope;
    square_sum = 55'(square_sum - recent_squares[square_slot] + sq);
    recent_squares[square_slot] = IntegratedW'(sq);
    square_slot = (square_slot + 1 >= WindowLength) ? 0 : square_slot + 1;
    for (int k = 11; k > 0; k--) recent_samples[k] = recent_samples[k-1];
    recent_samples[0] = SampleBits'(x);
    for (int k = 31; k > 0; k--) recent_lowpass[k] = recent_lowpass[k-1];
    recent_lowpass[0] = LowpassW'(lp);
    for (int k = 3; k > 0; k--) recent_highpass[k] = recent_highpass[k-1];
    recent_highpass[0] = HighpassW'(hp);
    res.lowpass    = LowpassW'(lp);
    res.highpass   = HighpassW'(hp);
    res.slope      = SlopeW'(slope);
    res.integrated = IntegratedW'(square_sum / WindowLength);
    return res;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SampleBits-1:0] clamp_sample(int v);
    if (v > 2047) return 12'sd2047;
    if (v < -2048) return -12'sd2048;
    return SampleBits'(v);
  endfunction

  task automatic add_sample(int v, bit start);
    sample_item_t item;
    item.ecg_sample      = clamp_sample(v);
    item.start_of_record = start;
    pending_samples.push_back(item);
  endtask

  task automatic report_error(string msg);
    error_count++;
    $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("** ecg_qrs_enhancement_filter: FAILED **");
      $finish;
    end
  end

  // Sample source: a new request goes out once the previous one is taken.
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_taken) begin
      if (send_gap != 0) begin
        sample_ch.valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        next_item = pending_samples.pop_front();
        sample_ch.valid           <= 1'b1;
        sample_ch.ecg_sample      <= next_item.ecg_sample;
        sample_ch.start_of_record <= next_item.start_of_record;
        if ($urandom_range(0, 59) == 0) send_steady = !send_steady;
        send_gap = pick_gap(send_steady);
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
      if ($urandom_range(0, 79) == 0) recv_steady = !recv_steady;
      if (!recv_steady && $urandom_range(0, 2) == 0) stall_left = pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    chain_result_t want;
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_ch.valid && sample_ch.ready;
      if (sample_ch.valid && sample_ch.ready) begin
        expected_results.push_back(filter_chain_step(
            '{ecg_sample: sample_ch.ecg_sample,
               start_of_record: sample_ch.start_of_record}));
        samples_sent++;
        if (sample_ch.start_of_record) record_starts++;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result arrived with no request outstanding (lowpass %0d)",
                                 result_ch.lowpass_value));
        end else begin
          want = expected_results.pop_front();
          if (result_ch.lowpass_value !== want.lowpass)
            report_error($sformatf("result %0d lowpass_value %0d, expected %0d",
                                   results_checked, result_ch.lowpass_value, want.lowpass));
          if (result_ch.highpass_value !== want.highpass)
            report_error($sformatf("result %0d highpass_value %0d, expected %0d",
                                   results_checked, result_ch.highpass_value, want.highpass));
          if (result_ch.slope_value !== want.slope)
            report_error($sformatf("result %0d slope_value %0d, expected %0d",
                                   results_checked, result_ch.slope_value, want.slope));
          if (result_ch.integrated_value !== want.integrated)
            report_error($sformatf("result %0d integrated_value %0d, expected %0d",
                                   results_checked, result_ch.integrated_value,
                                   want.integrated));
          if (longint'(want.integrated) > peak_mean) peak_mean = want.integrated;
          results_checked++;
        end
      end
    end
  end

  initial begin
    int random_count;
    int kind;
    int seg_len;
    int level;
    int baseline;
    int peak;
    int width;
    int peak_offset;
    int half_period;
    bit start;

    rst                       = 1'b1;
    sample_ch.valid           = 1'b0;
    sample_ch.ecg_sample      = '0;
    sample_ch.start_of_record = 1'b0;
    result_ch.ready           = 1'b0;
    error_count     = 0;
    samples_sent    = 0;
    record_starts   = 0;
    results_checked = 0;
    peak_mean       = 0;
    cycle_count     = 0;
    send_gap        = 0;
    send_steady     = 1'b0;
    stall_left      = 0;
    recv_steady     = 1'b0;
    clear_history();

    // Directed part: field extremes and alternating bit patterns straight out
    // of reset, a record start at full scale, a long full-scale run that drives
    // the low-pass towards its limit, then a record start and full-scale swings.
    add_sample(-2048, 1'b0);
    add_sample(2047, 1'b0);
    add_sample(0, 1'b0);
    add_sample(1, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(12'sh555, 1'b0);
    add_sample(-1366, 1'b0);
    add_sample(2047, 1'b1);
    for (int k = 0; k < 12; k++) add_sample(2047, 1'b0);
    add_sample(-2048, 1'b1);
    for (int k = 0; k < 4; k++) add_sample((k % 2) ? 2047 : -2048, 1'b0);

    // Random part: synthetic beats, steady levels, full-scale square waves
    // and raw noise, with occasional record starts.
    random_count = 0;
    while (random_count < RandomItems) begin
      kind  = $urandom_range(0, 9);
      start = ($urandom_range(0, 7) == 0);
      if (kind < 4) begin
        baseline = int'($urandom_range(0, 800)) - 400;
        peak     = $urandom_range(200, 2400);
        if ($urandom_range(0, 1)) peak = -peak;
        width    = $urandom_range(2, 8);
        seg_len  = $urandom_range(40, 90);
        for (int k = 0; k < seg_len; k++) begin
          level       = baseline + int'($urandom_range(0, 40)) - 20;
          peak_offset = (k > 20) ? k - 20 : 20 - k;
          if (peak_offset < width) level += peak * (width - peak_offset) / width;
          add_sample(level, start && k == 0);
        end
      end else if (kind < 6) begin
        level   = $urandom_range(0, 1) ? (($urandom_range(0, 1)) ? 2047 : -2048)
                                       : int'($urandom_range(0, 4095)) - 2048;
        seg_len = $urandom_range(10, 60);
        for (int k = 0; k < seg_len; k++) add_sample(level, start && k == 0);
      end else if (kind < 8) begin
        half_period = $urandom_range(1, 20);
        seg_len     = $urandom_range(20, 80);
        for (int k = 0; k < seg_len; k++)
          add_sample(((k / half_period) % 2) ? -2048 : 2047, start && k == 0);
      end else begin
        seg_len = $urandom_range(5, 30);
        for (int k = 0; k < seg_len; k++)
          add_sample(int'($urandom_range(0, 4095)) - 2048,
                     (start && k == 0) || $urandom_range(0, 99) == 0);
      end
      random_count += seg_len;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_samples.size() != 0 || sample_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (expected_results.size() != 0)
      report_error($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Sent %0d samples with %0d record starts; checked %0d results.",
             samples_sent, record_starts, results_checked);
    $display("Largest window mean seen: %0d; mismatches: %0d.", peak_mean, error_count);
    if (error_count == 0) begin
      $display("** ecg_qrs_enhancement_filter: PASSED **");
    end else begin
      $display("** ecg_qrs_enhancement_filter: FAILED **");
    end
    $finish;
  end

endmodule
